// ----- hdl/b2da_pkg.sv -----
// b2da_pkg: shared types, constants and helpers for the binary to ASCII
// decimal converter. No dependencies; used by every module in hdl/.
package b2da_pkg;

    // Field widths of the request and result ports
    localparam int NUMBER_W = 32;
    localparam int CHAR_W   = 6;
    localparam int DIGIT_W  = 4;

    // Default digit chain length; ten digits cover any 32-bit value
    localparam int MAX_DIGITS_DEF = 10;

    // Binary bits consumed by the cell chain in one cycle
    localparam int BITS_PER_CYCLE = 2;
    localparam int CONV_CYCLES    = NUMBER_W / BITS_PER_CYCLE;
    localparam int CONV_CNT_W     = $clog2(CONV_CYCLES);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

    typedef logic [DIGIT_W-1:0]        digit_t;
    typedef logic [BITS_PER_CYCLE-1:0] bits_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    // Commands from the controller to every cell of the chain
    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } cell_ctrl_t;

    // Status from the chain back to the controller
    typedef struct packed {
        logic top_zero;
        logic spill;
    } chain_status_t;

    // Add three to a BCD digit of five or more before it is doubled
    function automatic digit_t dd_adjust(input digit_t d);
        dd_adjust = (d >= DIGIT_FIVE) ? d + DIGIT_ADJ : d;
    endfunction

endpackage

// ----- hdl/b2da_cell.sv -----
// b2da_cell: one BCD digit of the double dabble chain.
// Depends on b2da_pkg (digit_t, bits_t, cell_ctrl_t, dd_adjust).
module b2da_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  b2da_pkg::cell_ctrl_t   ctrl,
    input  b2da_pkg::bits_t        bits_in,
    output b2da_pkg::bits_t        bits_out,
    input  b2da_pkg::digit_t       digit_in,
    output b2da_pkg::digit_t       digit_out
);

    b2da_pkg::digit_t digit_reg;
    b2da_pkg::digit_t digit_next;
    b2da_pkg::digit_t adj_first;
    b2da_pkg::digit_t mid_digit;
    b2da_pkg::digit_t adj_second;
    b2da_pkg::digit_t conv_digit;

    // Two adjust-and-double steps; the bit leaving each step goes upward
    always_comb
    begin
        adj_first  = b2da_pkg::dd_adjust(digit_reg);
        mid_digit  = {adj_first[2:0], bits_in[1]};
        adj_second = b2da_pkg::dd_adjust(mid_digit);
        conv_digit = {adj_second[2:0], bits_in[0]};
        bits_out   = {adj_first[3], adj_second[3]};
    end

    // Select clear, convert or move one place up during emission
    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = conv_digit;
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit_out = digit_reg;

endmodule

// ----- hdl/b2da_ctrl.sv -----
// b2da_ctrl: sequencer for conversion and digit emission.
// Depends on b2da_pkg (state_t, cell_ctrl_t, chain_status_t, constants).
module b2da_ctrl #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      last_digit,
    input  b2da_pkg::chain_status_t   status,
    output b2da_pkg::cell_ctrl_t      cells
);

    localparam int REM_W = $clog2(MAX_DIGITS + 1);

    b2da_pkg::state_t                      state_reg;
    b2da_pkg::state_t                      state_next;
    logic [b2da_pkg::CONV_CNT_W-1:0]       conv_cnt_reg;
    logic [b2da_pkg::CONV_CNT_W-1:0]       conv_cnt_next;
    logic [REM_W-1:0]                      remain_reg;
    logic [REM_W-1:0]                      remain_next;
    logic                                  started_reg;
    logic                                  started_next;
    logic                                  spill_reg;
    logic                                  spill_next;
    logic                                  lead;
    logic                                  on_last;
    logic                                  conv_done;

    assign on_last   = (remain_reg == REM_W'(1));
    assign conv_done = (conv_cnt_reg == '0);
    // A digit is shown once a nonzero digit is seen, on the units digit,
    // or always when the value spilled past the top cell
    assign lead      = spill_reg | started_reg | ~status.top_zero | on_last;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = b2da_pkg::ST_CONVERT;
                end
            end
            b2da_pkg::ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT:
            begin
                if (lead && !out_stall && on_last)
                begin
                    state_next = b2da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and cell commands
    always_comb
    begin
        in_stall      = (state_reg != b2da_pkg::ST_IDLE);
        out_valid     = (state_reg == b2da_pkg::ST_EMIT) && lead;
        last_digit    = on_last;
        cells.clear   = (state_reg == b2da_pkg::ST_IDLE) && in_valid;
        cells.convert = (state_reg == b2da_pkg::ST_CONVERT);
        cells.shift   = (state_reg == b2da_pkg::ST_EMIT) && (!lead || !out_stall);
    end

    // Counters and flags
    always_comb
    begin
        conv_cnt_next = conv_cnt_reg;
        remain_next   = remain_reg;
        started_next  = started_reg;
        spill_next    = spill_reg;
        if (cells.clear)
        begin
            conv_cnt_next = b2da_pkg::CONV_CNT_W'(b2da_pkg::CONV_CYCLES - 1);
            remain_next   = REM_W'(MAX_DIGITS);
            started_next  = 1'b0;
            spill_next    = 1'b0;
        end
        else if (cells.convert)
        begin
            conv_cnt_next = conv_cnt_reg - 1'b1;
            spill_next    = spill_reg | status.spill;
        end
        else if (cells.shift)
        begin
            remain_next  = remain_reg - 1'b1;
            started_next = started_reg | lead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= b2da_pkg::ST_IDLE;
            conv_cnt_reg <= '0;
            remain_reg   <= '0;
            started_reg  <= 1'b0;
            spill_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            conv_cnt_reg <= conv_cnt_next;
            remain_reg   <= remain_next;
            started_reg  <= started_next;
            spill_reg    <= spill_next;
        end
    end

    // An accepted request always starts a conversion
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == b2da_pkg::ST_CONVERT)
        else $error("accepted request did not start conversion");

    // Conversion ends after its fixed count
    a_conv_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == b2da_pkg::ST_CONVERT && conv_done |=> state_reg == b2da_pkg::ST_EMIT)
        else $error("conversion overran its count");

    // A stalled digit stays offered and the chain does not move
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(remain_reg))
        else $error("stalled digit was lost");

    // Emission never runs out of digits
    a_remain_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == b2da_pkg::ST_EMIT |-> remain_reg != '0)
        else $error("emission with no digits left");

endmodule

// ----- hdl/binary_to_decimal_ascii_core.sv -----
// binary_to_decimal_ascii_core: top level of the binary to ASCII decimal converter.
// Depends on b2da_pkg, b2da_cell and b2da_ctrl.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------
//  request  | in_valid / in_stall  | number[31:0]
//  result   | out_valid / out_stall| digit_char[5:0], last_digit
//
// A request is accepted, then converted (two bits a cycle through the chain
// of BCD cells); then its MAX_DIGITS digits move up to the top cell one by
// one, each leading zero skipped and each other digit shown. Only one
// request is in work at a time; in_stall is high from acceptance until the
// last digit is taken. out_stall holds the chain and the shown digit. Reset
// returns the block to idle.
module binary_to_decimal_ascii_core #(
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [b2da_pkg::NUMBER_W-1:0]  number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]    digit_char,
    output logic                           last_digit
);

    logic [b2da_pkg::NUMBER_W-1:0]  num_reg;
    logic [b2da_pkg::NUMBER_W-1:0]  num_next;
    b2da_pkg::cell_ctrl_t           cells;
    b2da_pkg::chain_status_t        status;
    b2da_pkg::bits_t                chain_bits  [MAX_DIGITS+1];
    b2da_pkg::digit_t               chain_digit [MAX_DIGITS+1];

    // Load the request, then feed its bits into the chain, top first
    always_comb
    begin
        num_next = num_reg;
        if (cells.clear)
        begin
            num_next = number;
        end
        else if (cells.convert)
        begin
            num_next = num_reg << b2da_pkg::BITS_PER_CYCLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= '0;
        end
        else
        begin
            num_reg <= num_next;
        end
    end

    assign chain_bits[0]  = num_reg[b2da_pkg::NUMBER_W-1 -: b2da_pkg::BITS_PER_CYCLE];
    assign chain_digit[0] = '0;

    // Row of digit cells, units digit at index zero
    for (genvar i = 0; i < MAX_DIGITS; i++)
    begin : g_cell
        b2da_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cells),
            .bits_in   (chain_bits[i]),
            .bits_out  (chain_bits[i+1]),
            .digit_in  (chain_digit[i]),
            .digit_out (chain_digit[i+1])
        );
    end

    assign status.top_zero = (chain_digit[MAX_DIGITS] == '0);
    assign status.spill    = |chain_bits[MAX_DIGITS];

    b2da_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .last_digit (last_digit),
        .status     (status),
        .cells      (cells)
    );

    // Top cell drives the shown character
    assign digit_char = b2da_pkg::ASCII_ZERO
                      + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, chain_digit[MAX_DIGITS]};

endmodule
